// File: hw/rtl/aac_js_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and the intensity gain table for the joint stereo pair unit
// no dependencies

package aac_js_pkg;

	localparam int CoefWidthDefault = 32;
	localparam int PortCoefWidth    = 32;
	localparam int SfWidth          = 9;
	localparam int GainWidth        = 29;
	localparam int GainShift        = 28;

	// right channel codebooks of interest
	localparam logic [3:0] CB_NOISE   = 4'd13;
	localparam logic [3:0] CB_INT_OUT = 4'd14;
	localparam logic [3:0] CB_INT_IN  = 4'd15;

	// ms mask modes
	localparam logic [1:0] MASK_FLAGS = 2'd1;
	localparam logic [1:0] MASK_ALL   = 2'd2;

	// configuration register indexes
	localparam logic [0:0] REG_STEREO_ENABLE = 1'd0;
	localparam logic [0:0] REG_MS_MASK_MODE  = 1'd1;

	typedef enum logic [1:0] {
		ACT_PASS,
		ACT_MS,
		ACT_INT
	} act_t;

	typedef struct packed {
		act_t       act;
		logic       neg;
		logic [1:0] frac;
	} ctl_t;

	// q28 values of 0.5^(frac/4)
	function automatic logic [GainWidth-1:0] gain_q28(input logic [1:0] frac);
		logic [GainWidth-1:0] g;
		case (frac)
			2'd0:    g = 29'd268435456;
			2'd1:    g = 29'd225726413;
			2'd2:    g = 29'd189812531;
			2'd3:    g = 29'd159612677;
			default: g = 29'd268435456;
		endcase
		return g;
	endfunction

endpackage

// File: hw/rtl/aac_js_decode.sv
`timescale 1ns / 1ps
// stage 1: band decode, mid/side sum and difference, intensity pre-shift
// depends on aac_js_pkg

module aac_js_decode #(
	parameter int COEF_WIDTH = aac_js_pkg::CoefWidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COEF_WIDTH-1:0]  left,
	input  logic signed [COEF_WIDTH-1:0]  right,
	input  logic [3:0]                    codebook,
	input  logic signed [aac_js_pkg::SfWidth-1:0] sf,
	input  logic                          ms_flag,
	input  logic                          stereo_enable,
	input  logic [1:0]                    ms_mask_mode,
	output logic                          valid_s1,
	input  logic                          out_ready,
	output logic signed [COEF_WIDTH-1:0]  lo_s1,
	output logic signed [COEF_WIDTH-1:0]  ro_s1,
	output aac_js_pkg::ctl_t              ctl_s1
);
	import aac_js_pkg::*;

	logic                          is_int;
	logic                          is_ms;
	logic [6:0]                    sh_left;
	logic signed [COEF_WIDTH-1:0]  v;
	ctl_t                          ctl;
	logic signed [COEF_WIDTH-1:0]  lo;
	logic signed [COEF_WIDTH-1:0]  ro;

	always_comb begin
		is_int = stereo_enable && (codebook == CB_INT_OUT || codebook == CB_INT_IN);
		is_ms  = stereo_enable && !is_int && (ms_flag || ms_mask_mode == MASK_ALL)
			&& codebook != CB_NOISE;
		// exponent is sf >>> 2; negative exponent shifts left
		sh_left = 7'd0 - sf[8:2];
		if (sf[8]) begin
			v = left << sh_left;
		end else begin
			v = left >>> sf[8:2];
		end
		ctl.neg  = (codebook == CB_INT_OUT) ^ (ms_mask_mode == MASK_FLAGS && ms_flag);
		ctl.frac = sf[1:0];
		if (is_int) begin
			ctl.act = ACT_INT;
			lo      = left;
			ro      = v;
		end else if (is_ms) begin
			ctl.act = ACT_MS;
			lo      = left + right;
			ro      = left - right;
		end else begin
			ctl.act = ACT_PASS;
			lo      = left;
			ro      = right;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			lo_s1  <= lo;
			ro_s1  <= ro;
			ctl_s1 <= ctl;
		end
	end

endmodule

// File: hw/rtl/aac_js_mult.sv
`timescale 1ns / 1ps
// stage 2: q28 gain multiply of the pre-shifted intensity value
// depends on aac_js_pkg

module aac_js_mult #(
	parameter int COEF_WIDTH = aac_js_pkg::CoefWidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	output logic                          ready_s1,
	input  logic signed [COEF_WIDTH-1:0]  lo_s1,
	input  logic signed [COEF_WIDTH-1:0]  ro_s1,
	input  aac_js_pkg::ctl_t              ctl_s1,
	output logic                          valid_s2,
	input  logic                          ready_s2,
	output logic signed [COEF_WIDTH-1:0]  lo_s2,
	output logic signed [COEF_WIDTH-1:0]  ro_s2,
	output logic signed [COEF_WIDTH+aac_js_pkg::GainWidth:0] prod_s2,
	output aac_js_pkg::ctl_t              ctl_s2
);
	import aac_js_pkg::*;

	localparam int ProdWidth = COEF_WIDTH + GainWidth + 1;

	logic signed [GainWidth:0]   gain;
	logic signed [ProdWidth-1:0] prod;

	assign gain = signed'({1'b0, gain_q28(ctl_s1.frac)});
	assign prod = ProdWidth'(ro_s1) * ProdWidth'(gain);

	assign ready_s1 = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			lo_s2   <= lo_s1;
			ro_s2   <= ro_s1;
			prod_s2 <= prod;
			ctl_s2  <= ctl_s1;
		end
	end

endmodule

// File: hw/rtl/aac_js_final.sv
`timescale 1ns / 1ps
// stage 3: q28 scale-down, intensity sign and result select into the output register
// depends on aac_js_pkg

module aac_js_final #(
	parameter int COEF_WIDTH = aac_js_pkg::CoefWidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	output logic                          ready_s2,
	input  logic signed [COEF_WIDTH-1:0]  lo_s2,
	input  logic signed [COEF_WIDTH-1:0]  ro_s2,
	input  logic signed [COEF_WIDTH+aac_js_pkg::GainWidth:0] prod_s2,
	input  aac_js_pkg::ctl_t              ctl_s2,
	output logic                          valid_s3,
	input  logic                          ready_s3,
	output logic signed [COEF_WIDTH-1:0]  lo_s3,
	output logic signed [COEF_WIDTH-1:0]  ro_s3
);
	import aac_js_pkg::*;

	logic signed [COEF_WIDTH-1:0] scaled;
	logic signed [COEF_WIDTH-1:0] ro;

	always_comb begin
		// floor shift by 28 then wrap is just a slice
		scaled = prod_s2[GainShift+COEF_WIDTH-1:GainShift];
		if (ctl_s2.neg) begin
			scaled = -scaled;
		end
		if (ctl_s2.act == ACT_INT) begin
			ro = scaled;
		end else begin
			ro = ro_s2;
		end
	end

	assign ready_s2 = !valid_s3 || ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			lo_s3 <= lo_s2;
			ro_s3 <= ro;
		end
	end

endmodule

// File: hw/rtl/aac_joint_stereo_pair_unit.sv
`timescale 1ns / 1ps
// top level of the joint stereo pair unit: stream ports, configuration registers, pipeline
// depends on aac_js_pkg, aac_js_decode, aac_js_mult, aac_js_final

// Rebuilds one left/right spectral coefficient pair per transaction: intensity bands
// get right = left scaled by 0.5^(scale_factor/4), mid/side bands become sum and
// difference, everything else passes through. The unit takes one pair every clock while
// the output is not stalled and returns it through a three-stage pipeline (decode and
// pre-shift, gain multiply, scale-down and select); the last stage is the output
// register. Backpressure on the output stalls the pipeline stage by stage, so
// s_axis_tready stays high while any stage is free. Coefficients are taken as the
// low COEF_WIDTH bits of each 32-bit field and results are sign-extended to 32 bits.
// Write the configuration registers only while no transaction is in flight.

module aac_joint_stereo_pair_unit #(
	parameter int COEF_WIDTH = aac_js_pkg::CoefWidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // left_coef[31:0], right_coef[63:32], scale_factor[72:64]
	input  logic [4:0]  s_axis_tuser,  // band_codebook[3:0], ms_flag[4]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // left_out[31:0], right_out[63:32]
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [1:0]  cfg_data
);
	import aac_js_pkg::*;

	localparam int ProdWidth = COEF_WIDTH + GainWidth + 1;

	logic                          stereo_enable_q;
	logic [1:0]                    ms_mask_mode_q;

	logic signed [COEF_WIDTH-1:0]  left;
	logic signed [COEF_WIDTH-1:0]  right;
	logic signed [SfWidth-1:0]     sf;

	logic                          valid_s1;
	logic                          ready_s1;
	logic signed [COEF_WIDTH-1:0]  lo_s1;
	logic signed [COEF_WIDTH-1:0]  ro_s1;
	ctl_t                          ctl_s1;

	logic                          valid_s2;
	logic                          ready_s2;
	logic signed [COEF_WIDTH-1:0]  lo_s2;
	logic signed [COEF_WIDTH-1:0]  ro_s2;
	logic signed [ProdWidth-1:0]   prod_s2;
	ctl_t                          ctl_s2;

	logic signed [COEF_WIDTH-1:0]  lo_s3;
	logic signed [COEF_WIDTH-1:0]  ro_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_enable_q <= 1'b0;
			ms_mask_mode_q  <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEREO_ENABLE: stereo_enable_q <= cfg_data[0];
				REG_MS_MASK_MODE:  ms_mask_mode_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign left  = s_axis_tdata[COEF_WIDTH-1:0];
	assign right = s_axis_tdata[PortCoefWidth+COEF_WIDTH-1:PortCoefWidth];
	assign sf    = s_axis_tdata[2*PortCoefWidth+SfWidth-1:2*PortCoefWidth];

	aac_js_decode #(.COEF_WIDTH(COEF_WIDTH)) u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.left          (left),
		.right         (right),
		.codebook      (s_axis_tuser[3:0]),
		.sf            (sf),
		.ms_flag       (s_axis_tuser[4]),
		.stereo_enable (stereo_enable_q),
		.ms_mask_mode  (ms_mask_mode_q),
		.valid_s1      (valid_s1),
		.out_ready     (ready_s1),
		.lo_s1         (lo_s1),
		.ro_s1         (ro_s1),
		.ctl_s1        (ctl_s1)
	);

	aac_js_mult #(.COEF_WIDTH(COEF_WIDTH)) u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.ready_s1 (ready_s1),
		.lo_s1    (lo_s1),
		.ro_s1    (ro_s1),
		.ctl_s1   (ctl_s1),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.lo_s2    (lo_s2),
		.ro_s2    (ro_s2),
		.prod_s2  (prod_s2),
		.ctl_s2   (ctl_s2)
	);

	aac_js_final #(.COEF_WIDTH(COEF_WIDTH)) u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ready_s2 (ready_s2),
		.lo_s2    (lo_s2),
		.ro_s2    (ro_s2),
		.prod_s2  (prod_s2),
		.ctl_s2   (ctl_s2),
		.valid_s3 (m_axis_tvalid),
		.ready_s3 (m_axis_tready),
		.lo_s3    (lo_s3),
		.ro_s3    (ro_s3)
	);

	assign m_axis_tdata[PortCoefWidth-1:0]               = PortCoefWidth'(lo_s3);
	assign m_axis_tdata[2*PortCoefWidth-1:PortCoefWidth] = PortCoefWidth'(ro_s3);

endmodule

// File: hw/rtl/aac_js_checker.sv
`timescale 1ns / 1ps
// port-level checks for the joint stereo pair unit, bound to the top level
// depends on aac_joint_stereo_pair_unit

module aac_js_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	// a free-running output never backs up the input
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// with the output ready while it passes the pipeline, an accepted transaction shows up at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
		|=> m_axis_tvalid)
		else $error("result missing after pipeline latency");

	// nothing comes out right after reset
	assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid coming out of reset");

endmodule

bind aac_joint_stereo_pair_unit aac_js_checker u_checker (.*);
